>>> design/keyword_lexer_top_macros.svh
// Assertion macros shared by the lexer top level.
`ifndef KEYWORD_LEXER_TOP_MACROS_SVH
`define KEYWORD_LEXER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define KL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define KL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/kl_pkg.sv
// Shared types, codes and character constants for the keyword lexer.
`timescale 1ns / 1ps

package kl_pkg;

  localparam int OUT_W       = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    KIND_EXIT   = 4'd0,
    KIND_VAR    = 4'd1,
    KIND_IDENT  = 4'd2,
    KIND_INT    = 4'd3,
    KIND_LPAREN = 4'd4,
    KIND_RPAREN = 4'd5,
    KIND_SEMI   = 4'd6,
    KIND_EQUALS = 4'd7,
    KIND_ERROR  = 4'd8,
    KIND_END    = 4'd9
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_NUM   = 2'd2,
    MODE_HALT  = 2'd3
  } scan_mode_t;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;

  typedef struct packed {
    logic        vld;
    token_kind_t kind;
    logic [15:0] start;
    logic [15:0] len;
  } token_t;

  // Up to three tokens come out of one character: a flushed token, a
  // single-character (or end-flushed) token, and the end token.
  typedef struct packed {
    token_t [2:0] slot;
  } bundle_t;

  function automatic logic [7:0] exit_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h65;
      2'd1:    c = 8'h78;
      2'd2:    c = 8'h69;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] var_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h76;
      2'd1:    c = 8'h61;
      2'd2:    c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> design/keyword_lexer_top.sv
// A character's token words pass through the bundle queue and then the output register.
// Throughput: one character per cycle while out_stall is low and each character yields at most one token word;
// the output register sends one word per cycle, so a character yielding three holds the queue.
// The two-entry bundle queue between the scanner and the output stage sets the stall depth.
// Reset (synchronous, rst_n low) returns the scanner to idle at position zero and empties
// the queue; an error token halts scanning until the next reset.
`timescale 1ns / 1ps
`include "keyword_lexer_top_macros.svh"

module keyword_lexer_top import kl_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [15:0] out_start_pos,
  output logic [15:0] out_length,
  output logic        out_last_of_run
);

  logic    q_full, q_push, q_pop, q_head_valid;
  bundle_t q_push_data, q_head_data;

  kl_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_end_of_source (in_end_of_source),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_push_data)
  );

  kl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  kl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_data       (q_head_data),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_start_pos   (out_start_pos),
    .out_length      (out_length),
    .out_last_of_run (out_last_of_run)
  );

  // Nothing follows an error or end token from the same character.
  `KL_ASSERT_NOW(a_error_is_last, out_valid && out_kind == KIND_ERROR, out_last_of_run, "error word not last")
  `KL_ASSERT_NOW(a_end_is_last, out_valid && out_kind == KIND_END, out_last_of_run, "end word not last")
  `KL_ASSERT_NOW(a_end_empty, out_valid && out_kind == KIND_END, out_length == 16'd0, "end word has length")
  // A word left waiting by a stall is still there on the next cycle.
  `KL_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_kind), "stalled word lost")

endmodule

>>> design/kl_front.sv
// Front end: classifies each character, tracks the pending token and builds token bundles.
`timescale 1ns / 1ps

module kl_front import kl_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_source,
  input  logic       q_full,
  output logic       q_push,
  output bundle_t    q_data
);

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
  localparam logic [POS_WIDTH-1:0] LEN_ONE = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] LEN_THR = POS_WIDTH'(3);
  localparam logic [POS_WIDTH-1:0] LEN_FOU = POS_WIDTH'(4);

  scan_mode_t             mode_r, mode_nxt, mid_mode;
  logic [POS_WIDTH-1:0]   pos_r, pos_nxt;
  logic [POS_WIDTH-1:0]   tstart_r, tstart_nxt, mid_start;
  logic [POS_WIDTH-1:0]   tlen_r, tlen_nxt, mid_len;
  logic [1:0]             flags_r, flags_nxt, mid_flags;
  logic                   accept;
  logic                   is_alpha, is_digit, is_space, is_single;
  logic                   halted, pending, extend;
  logic                   start_flush, single_v, err_v, last_flush, end_v;
  token_kind_t            single_kind;

  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
    return (v == POS_MAX) ? v : v + LEN_ONE;
  endfunction

  function automatic logic [15:0] to_out(input logic [POS_WIDTH-1:0] v);
    logic [POS_WIDTH+15:0] ext;
    ext = {16'b0, v};
    return ext[15:0];
  endfunction

  // A keyword flag survives only while the character matches at this offset.
  function automatic logic [1:0] upd_flags(input logic [7:0] c,
                                           input logic [POS_WIDTH-1:0] len,
                                           input logic [1:0] flags);
    logic [1:0] f;
    f = flags;
    if (!(len < LEN_FOU && c == exit_char(len[1:0]))) f[0] = 1'b0;
    if (!(len < LEN_THR && c == var_char(len[1:0]))) f[1] = 1'b0;
    return f;
  endfunction

  function automatic token_t flush_tok(input scan_mode_t m, input logic [1:0] flags,
                                       input logic [POS_WIDTH-1:0] start,
                                       input logic [POS_WIDTH-1:0] len);
    token_t t;
    t.vld   = 1'b1;
    t.start = to_out(start);
    t.len   = to_out(len);
    if (m == MODE_NUM) t.kind = KIND_INT;
    else if (flags[0] && len == LEN_FOU) t.kind = KIND_EXIT;
    else if (flags[1] && len == LEN_THR) t.kind = KIND_VAR;
    else t.kind = KIND_IDENT;
    return t;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Character classes.
  always_comb begin
    is_alpha  = (in_ch inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    is_digit  = (in_ch inside {[8'h30:8'h39]});
    is_space  = (in_ch inside {8'h20, [8'h09:8'h0D]});
    is_single = 1'b1;
    case (in_ch)
      CH_LPAREN: single_kind = KIND_LPAREN;
      CH_RPAREN: single_kind = KIND_RPAREN;
      CH_SEMI:   single_kind = KIND_SEMI;
      CH_EQUALS: single_kind = KIND_EQUALS;
      default: begin
        single_kind = KIND_ERROR;
        is_single   = 1'b0;
      end
    endcase
  end

  assign halted      = (mode_r == MODE_HALT);
  assign pending     = (mode_r == MODE_IDENT) || (mode_r == MODE_NUM);
  assign extend      = ((mode_r == MODE_IDENT) && (is_alpha || is_digit)) ||
                       ((mode_r == MODE_NUM) && is_digit);
  assign start_flush = !halted && !extend && pending;
  assign single_v    = !halted && is_single;
  assign err_v       = !halted && !extend && !is_alpha && !is_digit && !is_single && !is_space;

  // Token state after the character itself, before the end-of-source handling.
  always_comb begin
    mid_mode  = mode_r;
    mid_start = tstart_r;
    mid_len   = tlen_r;
    mid_flags = flags_r;
    if (!halted) begin
      if (extend) begin
        mid_len = sat_inc(tlen_r);
        if (mode_r == MODE_IDENT) mid_flags = upd_flags(in_ch, tlen_r, flags_r);
      end else if (is_alpha) begin
        mid_mode  = MODE_IDENT;
        mid_start = pos_r;
        mid_len   = LEN_ONE;
        mid_flags = upd_flags(in_ch, '0, 2'b11);
      end else if (is_digit) begin
        mid_mode  = MODE_NUM;
        mid_start = pos_r;
        mid_len   = LEN_ONE;
        mid_flags = 2'b00;
      end else begin
        mid_mode  = err_v ? MODE_HALT : MODE_IDLE;
        mid_len   = '0;
        mid_flags = 2'b00;
      end
    end
  end

  assign last_flush = !halted && in_end_of_source &&
                      ((mid_mode == MODE_IDENT) || (mid_mode == MODE_NUM));
  assign end_v      = !halted && in_end_of_source && (mid_mode != MODE_HALT);

  // Next register values.
  always_comb begin
    mode_nxt   = mid_mode;
    tstart_nxt = mid_start;
    tlen_nxt   = mid_len;
    flags_nxt  = mid_flags;
    pos_nxt    = halted ? pos_r : sat_inc(pos_r);
    if (end_v) begin
      mode_nxt   = MODE_IDLE;
      tstart_nxt = '0;
      tlen_nxt   = '0;
      flags_nxt  = 2'b00;
      pos_nxt    = '0;
    end
  end

  // Token bundle for the queue.
  always_comb begin
    q_data = '0;
    if (start_flush) q_data.slot[0] = flush_tok(mode_r, flags_r, tstart_r, tlen_r);
    if (single_v || err_v) begin
      q_data.slot[1].vld   = 1'b1;
      q_data.slot[1].kind  = single_kind;
      q_data.slot[1].start = to_out(pos_r);
      q_data.slot[1].len   = 16'd1;
    end else if (last_flush) begin
      q_data.slot[1] = flush_tok(mid_mode, mid_flags, mid_start, mid_len);
    end
    if (end_v) begin
      q_data.slot[2].vld   = 1'b1;
      q_data.slot[2].kind  = KIND_END;
      q_data.slot[2].start = to_out(sat_inc(pos_r));
      q_data.slot[2].len   = 16'd0;
    end
    q_push = accept && (q_data.slot[0].vld || q_data.slot[1].vld || q_data.slot[2].vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= '0;
      flags_r  <= 2'b00;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      flags_r  <= flags_nxt;
    end
  end

endmodule

>>> design/kl_queue.sv
// Short queue of token bundles between the front and back ends.
`timescale 1ns / 1ps

module kl_queue import kl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  bundle_t           entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> design/kl_back.sv
// Back end: unpacks each bundle into result words through an output register.
`timescale 1ns / 1ps

module kl_back import kl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  bundle_t     head_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [15:0] out_start_pos,
  output logic [15:0] out_length,
  output logic        out_last_of_run
);

  logic [2:0]  done_r, done_nxt;
  logic [2:0]  pend, sel_oh, remain;
  logic        load;
  logic        valid_r;
  token_t      tok_r, sel_tok;
  logic        last_r;

  assign pend = {head_data.slot[2].vld, head_data.slot[1].vld, head_data.slot[0].vld} & ~done_r;

  always_comb begin
    if (pend[0]) begin
      sel_oh  = 3'b001;
      sel_tok = head_data.slot[0];
    end else if (pend[1]) begin
      sel_oh  = 3'b010;
      sel_tok = head_data.slot[1];
    end else begin
      sel_oh  = 3'b100;
      sel_tok = head_data.slot[2];
    end
  end

  assign remain = pend & ~sel_oh;
  assign load   = head_valid && (pend != 3'b000) && (!valid_r || !out_stall);
  assign pop    = load && (remain == 3'b000);

  always_comb begin
    done_nxt = done_r;
    if (load) done_nxt = (remain == 3'b000) ? 3'b000 : (done_r | sel_oh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= 3'b000;
      valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (load) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= sel_tok;
      last_r <= (remain == 3'b000);
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = tok_r.kind;
  assign out_start_pos   = tok_r.start;
  assign out_length      = tok_r.len;
  assign out_last_of_run = last_r;

endmodule

>>> sim/keyword_lexer_top_tb.sv
// Self-checking testbench for the keyword lexer top level.
`timescale 1ns / 1ps

module keyword_lexer_top_tb import kl_pkg::*;;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 22;

  localparam logic [31:0] EXIT_TEXT = "exit";
  localparam logic [23:0] VAR_TEXT  = "var";

  typedef struct {
    token_kind_t kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } lex_token_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch            = 8'd0;
  logic        in_end_of_source = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [3:0]  out_kind;
  logic [15:0] out_start_pos;
  logic [15:0] out_length;
  logic        out_last_of_run;

  bit gaps_on = 1'b1;
  int fault_count = 0;
  int token_count = 0;
  int quiet_cycles = 0;

  // Scanner state as the tokens are predicted.
  scan_mode_t  lx_mode  = MODE_IDLE;
  logic [15:0] lx_pos   = 16'd0;
  logic [15:0] lx_start = 16'd0;
  logic [15:0] lx_len   = 16'd0;
  logic [1:0]  lx_flags = 2'b00;

  lex_token_t  expected_tokens[$];
  logic [7:0]  source_text[$];

  keyword_lexer_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_start_pos    (out_start_pos),
    .out_length       (out_length),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [15:0] sat_next(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  task automatic add_token(input token_kind_t k, input logic [15:0] s, input logic [15:0] l);
    lex_token_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.last  = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
  endtask

  task automatic queue_char(input logic [7:0] c);
    source_text.insert(source_text.size(), c);
  endtask

  // Drops each keyword flag as soon as the pending identifier departs from that word.
  task automatic track_keywords(input logic [7:0] c);
    if (!(lx_len < 16'd4 && c == EXIT_TEXT[8 * (3 - lx_len[1:0]) +: 8])) lx_flags[0] = 1'b0;
    if (!(lx_len < 16'd3 && c == VAR_TEXT[8 * (2 - lx_len[1:0]) +: 8])) lx_flags[1] = 1'b0;
  endtask

  task automatic flush_pending();
    token_kind_t k;
    if (lx_mode == MODE_IDENT) begin
      if (lx_flags[0] && lx_len == 16'd4) k = KIND_EXIT;
      else if (lx_flags[1] && lx_len == 16'd3) k = KIND_VAR;
      else k = KIND_IDENT;
    end else if (lx_mode == MODE_NUM) begin
      k = KIND_INT;
    end else begin
      return;
    end
    add_token(k, lx_start, lx_len);
    lx_mode  = MODE_IDLE;
    lx_len   = 16'd0;
    lx_flags = 2'b00;
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic eos);
    int n_before;
    n_before = expected_tokens.size();
    if (lx_mode == MODE_HALT) return;
    if (lx_mode == MODE_IDENT && (is_letter(c) || is_digit(c))) begin
      track_keywords(c);
      lx_len = sat_next(lx_len);
    end else if (lx_mode == MODE_NUM && is_digit(c)) begin
      lx_len = sat_next(lx_len);
    end else begin
      flush_pending();
      if (is_letter(c)) begin
        lx_mode  = MODE_IDENT;
        lx_start = lx_pos;
        lx_len   = 16'd0;
        lx_flags = 2'b11;
        track_keywords(c);
        lx_len   = 16'd1;
      end else if (is_digit(c)) begin
        lx_mode  = MODE_NUM;
        lx_start = lx_pos;
        lx_len   = 16'd1;
      end else if (c == CH_LPAREN) begin
        add_token(KIND_LPAREN, lx_pos, 16'd1);
      end else if (c == CH_RPAREN) begin
        add_token(KIND_RPAREN, lx_pos, 16'd1);
      end else if (c == CH_SEMI) begin
        add_token(KIND_SEMI, lx_pos, 16'd1);
      end else if (c == CH_EQUALS) begin
        add_token(KIND_EQUALS, lx_pos, 16'd1);
      end else if (!is_blank(c)) begin
        add_token(KIND_ERROR, lx_pos, 16'd1);
        lx_mode  = MODE_HALT;
        lx_len   = 16'd0;
        lx_flags = 2'b00;
      end
    end
    lx_pos = sat_next(lx_pos);
    if (eos && lx_mode != MODE_HALT) begin
      flush_pending();
      add_token(KIND_END, lx_pos, 16'd0);
      lx_mode  = MODE_IDLE;
      lx_pos   = 16'd0;
      lx_start = 16'd0;
      lx_len   = 16'd0;
      lx_flags = 2'b00;
    end
    // Only words added for this character are touched here.
    if (expected_tokens.size() > n_before)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endtask

  // The word is predicted as soon as it is offered: it cannot change until taken.
  task automatic send_char(input logic [7:0] c, input logic eos);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_ch            <= c;
    in_end_of_source <= eos;
    predict_tokens(c, eos);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic append_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  task automatic send_source(input bit closed);
    int i;
    for (i = 0; i < source_text.size(); i++)
      send_char(source_text[i], closed && i == source_text.size() - 1);
    source_text.delete();
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    logic [7:0] offs;
    base = $urandom_range(0, 1) ? "a" : "A";
    offs = 8'($urandom_range(0, 25));
    return base + offs;
  endfunction

  function automatic logic [7:0] rand_digit();
    logic [7:0] offs;
    offs = 8'($urandom_range(0, 9));
    return "0" + offs;
  endfunction

  function automatic logic [7:0] rand_blank();
    logic [7:0] idx;
    idx = 8'($urandom_range(0, 5));
    return (idx == 8'd0) ? 8'h20 : 8'd8 + idx;
  endfunction

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(0, 3))
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_SEMI;
      default: return CH_EQUALS;
    endcase
  endfunction

  function automatic string near_keyword();
    case ($urandom_range(0, 7))
      0:       return "exi";
      1:       return "exits";
      2:       return "Exit";
      3:       return "va";
      4:       return "vars";
      5:       return "vAr";
      6:       return "ex1t";
      default: return "var9";
    endcase
  endfunction

  // Mostly well-formed statements; words often abut so that boundaries fall mid-token.
  task automatic build_random_source();
    int pieces;
    int p;
    int i;
    int n;
    pieces = $urandom_range(1, 7);
    for (p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 7))
        0: append_text("exit");
        1: append_text("var");
        2: append_text(near_keyword());
        3: begin
          n = $urandom_range(1, 6);
          queue_char(rand_letter());
          for (i = 1; i < n; i++)
            queue_char($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
        end
        4: begin
          n = $urandom_range(1, 5);
          for (i = 0; i < n; i++) queue_char(rand_digit());
        end
        5, 6: queue_char(rand_punct());
        default: begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) queue_char(rand_blank());
        end
      endcase
      if ($urandom_range(0, 1)) queue_char(rand_blank());
    end
  endtask

  task automatic test_directed_tokens();
    // Keywords, a miss on case, and an identifier closed by a bracket.
    append_text("exit\tvar(Exit)");
    send_source(1'b0);
    // The remaining blanks, then a number ended by a letter and a letter ended by a semicolon.
    queue_char(8'd13);
    queue_char(8'd11);
    queue_char(8'd12);
    queue_char(8'd10);
    append_text("09x;");
    send_source(1'b0);
    // The final character closes an identifier, gives its own word and the end token.
    append_text("vars=");
    send_source(1'b1);
    // A source of one blank gives the end token alone.
    append_text(" ");
    send_source(1'b1);
  endtask

  task automatic test_random_sources(input int item_budget);
    int sent;
    sent = 0;
    while (sent < item_budget) begin
      build_random_source();
      sent += source_text.size();
      send_source(1'b1);
    end
  endtask

  task automatic test_back_to_back(input int item_budget);
    gaps_on = 1'b0;
    test_random_sources(item_budget);
    gaps_on = 1'b1;
  endtask

  // Must run last: the block stays halted until the next reset.
  task automatic test_error_halt();
    int i;
    logic [7:0] c;
    append_text("ab");
    queue_char(8'hFF);
    send_source(1'b1);
    for (i = 0; i < 12; i++) begin
      c = 8'($urandom_range(0, 255));
      send_char(c, i == 11 ? 1'b1 : 1'($urandom_range(0, 1)));
    end
  endtask

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
  end

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("token %0d: %s", token_count, what);
  endtask

  always @(posedge clk) begin : check_tokens
    lex_token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_fault($sformatf("unexpected word kind %0d start %0d len %0d",
                               out_kind, out_start_pos, out_length));
      end else begin
        want = expected_tokens.pop_front();
        if (out_kind !== want.kind || out_start_pos !== want.start ||
            out_length !== want.len || out_last_of_run !== want.last)
          report_fault($sformatf("exp kind %0d start %0d len %0d last %0b, got %0d %0d %0d %0b",
                                 want.kind, want.start, want.len, want.last,
                                 out_kind, out_start_pos, out_length, out_last_of_run));
      end
      token_count++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL keyword_lexer_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_tokens();
    test_random_sources(60);
    test_back_to_back(30);
    test_error_halt();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_tokens.size() == 0) begin
      $display("PASS keyword_lexer_top");
    end else begin
      $display("FAIL keyword_lexer_top");
    end
    $finish;
  end

endmodule
